@@ hw/rtl/cmms_pkg.sv @@
// Package with the shared types, codes and compare helpers of the column statistics block.
package cmms_pkg;

    localparam int COUNT_BITS = 48;
    localparam int OUT_BITS   = 48;

    localparam logic [2:0] TY_BOOL = 3'd0;
    localparam logic [2:0] TY_I32  = 3'd1;
    localparam logic [2:0] TY_I64  = 3'd2;
    localparam logic [2:0] TY_I96  = 3'd3;
    localparam logic [2:0] TY_F32  = 3'd4;
    localparam logic [2:0] TY_F64  = 3'd5;

    localparam logic [1:0] CMD_VALUE = 2'd0;
    localparam logic [1:0] CMD_NULL  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] REG_VALUE_TYPE     = 2'd0;
    localparam logic [1:0] REG_UNSIGNED_ORDER = 2'd1;

    localparam logic [63:0] F32_MAX_BITS  = 64'h0000_0000_7F7F_FFFF;
    localparam logic [63:0] F32_LOW_BITS  = 64'h0000_0000_FF7F_FFFF;
    localparam logic [63:0] F32_NEG_ZERO  = 64'h0000_0000_8000_0000;
    localparam logic [63:0] F64_MAX_BITS  = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] F64_LOW_BITS  = 64'hFFEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] F64_NEG_ZERO  = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] hi;
    } t_val;

    typedef struct packed {
        t_val mn;
        t_val mx;
    } t_pair;

    function automatic logic [2:0] eff_type(input logic [2:0] vt);
        return (vt <= TY_F64) ? vt : TY_I64;
    endfunction

    function automatic t_val normalize(input logic [2:0] t, input t_val v);
        t_val r;
        r.hi = '0;
        r.lo = v.lo;
        case (t)
            TY_BOOL:        r.lo = {63'd0, v.lo[0]};
            TY_I32, TY_F32: r.lo = {32'd0, v.lo[31:0]};
            TY_I96:         r.hi = v.hi;
            default:        r.lo = v.lo;
        endcase
        return r;
    endfunction

    function automatic logic f32_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != '0);
    endfunction

    function automatic logic f64_nan(input logic [63:0] a);
        return (a[62:52] == 11'h7FF) && (a[51:0] != '0);
    endfunction

    function automatic logic f32_less(input logic [31:0] a, input logic [31:0] b);
        logic r;
        r = 1'b0;
        if (f32_nan(a) || f32_nan(b) || (a[30:0] == '0 && b[30:0] == '0)) begin
            r = 1'b0;
        end else if (a[31] != b[31]) begin
            r = a[31];
        end else if (a[31]) begin
            r = a[30:0] > b[30:0];
        end else begin
            r = a[30:0] < b[30:0];
        end
        return r;
    endfunction

    function automatic logic f64_less(input logic [63:0] a, input logic [63:0] b);
        logic r;
        r = 1'b0;
        if (f64_nan(a) || f64_nan(b) || (a[62:0] == '0 && b[62:0] == '0)) begin
            r = 1'b0;
        end else if (a[63] != b[63]) begin
            r = a[63];
        end else if (a[63]) begin
            r = a[62:0] > b[62:0];
        end else begin
            r = a[62:0] < b[62:0];
        end
        return r;
    endfunction

    // Signed integer order is unsigned order with the sign bit flipped.
    function automatic logic is_less(input logic [2:0] t, input logic uns,
                                     input t_val a, input t_val b);
        logic [31:0] ka;
        logic [31:0] kb;
        logic [63:0] wa;
        logic [63:0] wb;
        logic        r;
        ka = a.hi ^ {~uns, 31'd0};
        kb = b.hi ^ {~uns, 31'd0};
        wa = a.lo ^ {~uns, 63'd0};
        wb = b.lo ^ {~uns, 63'd0};
        case (t)
            TY_BOOL: r = a.lo[0] < b.lo[0];
            TY_I32:  r = (a.lo[31:0] ^ {~uns, 31'd0}) < (b.lo[31:0] ^ {~uns, 31'd0});
            TY_I96:  r = (ka != kb) ? (ka < kb) : (a.lo < b.lo);
            TY_F32:  r = f32_less(a.lo[31:0], b.lo[31:0]);
            TY_F64:  r = f64_less(a.lo, b.lo);
            default: r = wa < wb;
        endcase
        return r;
    endfunction

    function automatic t_pair defaults(input logic [2:0] t, input logic uns);
        t_pair p;
        p.mn.hi = '0;
        p.mx.hi = '0;
        case (t)
            TY_BOOL: begin
                p.mn.lo = 64'd1;
                p.mx.lo = 64'd0;
            end
            TY_I32: begin
                p.mn.lo = uns ? 64'hFFFF_FFFF : 64'h7FFF_FFFF;
                p.mx.lo = uns ? 64'd0 : 64'h8000_0000;
            end
            TY_I96: begin
                p.mn.lo = '1;
                p.mn.hi = uns ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
                p.mx.lo = '0;
                p.mx.hi = uns ? 32'd0 : 32'h8000_0000;
            end
            TY_F32: begin
                p.mn.lo = F32_MAX_BITS;
                p.mx.lo = F32_LOW_BITS;
            end
            TY_F64: begin
                p.mn.lo = F64_MAX_BITS;
                p.mx.lo = F64_LOW_BITS;
            end
            default: begin
                p.mn.lo = uns ? '1 : 64'h7FFF_FFFF_FFFF_FFFF;
                p.mx.lo = uns ? 64'd0 : F64_NEG_ZERO;
            end
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/cmms_if.sv @@
// Channel interfaces for slot requests, statistics results and configuration writes.
interface cmms_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] value_low;
    logic [31:0] value_high;
    logic        last_in_batch;
    modport source (output valid, cmd, value_low, value_high, last_in_batch, input ready);
    modport sink   (input valid, cmd, value_low, value_high, last_in_batch, output ready);
endinterface

interface cmms_stat_if;
    logic        valid;
    logic        ready;
    logic        extremes_valid;
    logic [63:0] min_low;
    logic [31:0] min_high;
    logic [63:0] max_low;
    logic [31:0] max_high;
    logic [47:0] null_total;
    logic [47:0] value_total;
    modport source (output valid, extremes_valid, min_low, min_high, max_low, max_high,
                    null_total, value_total, input ready);
    modport sink   (input valid, extremes_valid, min_low, min_high, max_low, max_high,
                    null_total, value_total, output ready);
endinterface

interface cmms_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [2:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/column_min_max_statistics.sv @@
// Top level of the column statistics block: counters, batch extremes and recorded totals.
//
//  channel  | direction | carries
//  i_item   | in        | slot request: cmd, value, last_in_batch
//  o_stat   | out       | totals after each request
//  i_cfg    | in        | register writes: value_type, unsigned_order
//
// One request is taken per cycle unless the output stalls; its result appears in the
// output register on the next cycle. The fold and the batch merge are one
// compare-and-select each, both combinational. A stalled output only holds the input
// while the output register is full and not taken. Synchronous reset restores all state but the batch extremes.
module column_min_max_statistics (
    input  logic i_clk,
    input  logic i_rst_n,
    cmms_item_if.sink   i_item,
    cmms_stat_if.source o_stat,
    cmms_cfg_if.sink    i_cfg
);
    import cmms_pkg::*;

    logic [2:0]            r_value_type;
    logic                  r_unsigned_order;
    t_val                  r_bmin, r_bmax, n_bmin, n_bmax;
    logic                  r_bhv, n_bhv;
    logic                  r_have, n_have;
    t_val                  r_tmin, r_tmax, n_tmin, n_tmax;
    logic [COUNT_BITS-1:0] r_nulls, r_vals, n_nulls, n_vals;
    logic                  r_out_valid;

    logic [2:0] t;
    t_val       v, in_raw, cur_min, cur_max, mn, mx;
    t_pair      dflt;
    logic       is_value, is_nan, fold, accept, keep;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = !r_out_valid || o_stat.ready;
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        t        = eff_type(r_value_type);
        dflt     = defaults(t, r_unsigned_order);
        in_raw   = '{lo: i_item.value_low, hi: i_item.value_high};
        v        = normalize(t, in_raw);
        is_value = i_item.cmd == CMD_VALUE;
        is_nan   = (t == TY_F32 && f32_nan(v.lo[31:0])) || (t == TY_F64 && f64_nan(v.lo));
        fold     = is_value && !is_nan;
        // A batch without values holds the defaults of the current setup.
        cur_min  = r_bhv ? r_bmin : dflt.mn;
        cur_max  = r_bhv ? r_bmax : dflt.mx;
        n_bmin   = (fold && !is_less(t, r_unsigned_order, cur_min, v)) ? v : cur_min;
        n_bmax   = (fold && is_less(t, r_unsigned_order, cur_max, v)) ? v : cur_max;
        n_bhv    = r_bhv || is_value;
        n_vals   = r_vals;
        n_nulls  = r_nulls;
        if (is_value && r_vals != '1) n_vals = r_vals + 1'b1;
        if (i_item.cmd == CMD_NULL && r_nulls != '1) n_nulls = r_nulls + 1'b1;

        // Batch close with the floating-point cleanup.
        mn   = n_bmin;
        mx   = n_bmax;
        keep = 1'b1;
        if (t == TY_F32) begin
            if (mn.lo == F32_MAX_BITS && mx.lo == F32_LOW_BITS) keep = 1'b0;
            if (mn.lo == '0) mn.lo = F32_NEG_ZERO;
            if (mx.lo == F32_NEG_ZERO) mx.lo = '0;
        end else if (t == TY_F64) begin
            if (mn.lo == F64_MAX_BITS && mx.lo == F64_LOW_BITS) keep = 1'b0;
            if (mn.lo == '0) mn.lo = F64_NEG_ZERO;
            if (mx.lo == F64_NEG_ZERO) mx.lo = '0;
        end
        n_have = r_have;
        n_tmin = r_tmin;
        n_tmax = r_tmax;
        if (i_item.last_in_batch && n_bhv && keep) begin
            n_have = 1'b1;
            if (!r_have || !is_less(t, r_unsigned_order, r_tmin, mn)) n_tmin = mn;
            if (!r_have || !is_less(t, r_unsigned_order, mx, r_tmax)) n_tmax = mx;
        end
        if (i_item.last_in_batch) n_bhv = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_type     <= TY_I32;
            r_unsigned_order <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_VALUE_TYPE:     r_value_type     <= i_cfg.data;
                REG_UNSIGNED_ORDER: r_unsigned_order <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bhv       <= 1'b0;
            r_have      <= 1'b0;
            r_tmin      <= '0;
            r_tmax      <= '0;
            r_nulls     <= '0;
            r_vals      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_stat.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept && i_item.cmd == CMD_CLEAR) begin
                r_bhv   <= 1'b0;
                r_have  <= 1'b0;
                r_tmin  <= '0;
                r_tmax  <= '0;
                r_nulls <= '0;
                r_vals  <= '0;
            end else if (accept) begin
                r_bhv   <= n_bhv;
                r_have  <= n_have;
                r_tmin  <= n_tmin;
                r_tmax  <= n_tmax;
                r_nulls <= n_nulls;
                r_vals  <= n_vals;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bmin <= n_bmin;
            r_bmax <= n_bmax;
        end
    end

    assign o_stat.valid          = r_out_valid;
    assign o_stat.extremes_valid = r_have;
    assign o_stat.min_low        = r_tmin.lo;
    assign o_stat.min_high       = r_tmin.hi;
    assign o_stat.max_low        = r_tmax.lo;
    assign o_stat.max_high       = r_tmax.hi;
    assign o_stat.null_total     = OUT_BITS'(r_nulls);
    assign o_stat.value_total    = OUT_BITS'(r_vals);

endmodule

@@ tb/column_min_max_statistics_test.sv @@
// Testbench for the column statistics block: random slot requests checked against a predictor.
module column_min_max_statistics_test;
    import cmms_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 4;

    // Codes outside the defined sets, used to probe the fallback behavior.
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [2:0] TY_SPARE  = 3'd7;

    typedef struct {
        logic [1:0]  cmd;
        logic [63:0] lo;
        logic [31:0] hi;
        logic        last;
    } t_slot;

    typedef struct {
        logic        has;
        logic [63:0] min_lo;
        logic [31:0] min_hi;
        logic [63:0] max_lo;
        logic [31:0] max_hi;
        logic [47:0] nulls;
        logic [47:0] vals;
    } t_stats;

    logic i_clk;
    logic i_rst_n;

    cmms_item_if item ();
    cmms_stat_if stat ();
    cmms_cfg_if  cfg ();

    column_min_max_statistics dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .o_stat  (stat),
        .i_cfg   (cfg)
    );

    t_slot  pending_slots[$];
    t_stats expected_stats[$];
    int     error_count;
    int     cycle_count;
    logic   req_taken;
    int     burst_left;
    int     gap_left;
    int     stall_mode;
    int     stall_left;

    // Shadow of the block's registers and state.
    logic [2:0]  sh_type;
    logic        sh_uns;
    logic [63:0] bmin_lo;
    logic [31:0] bmin_hi;
    logic [63:0] bmax_lo;
    logic [31:0] bmax_hi;
    logic        batch_open;
    logic        have_totals;
    logic [63:0] tmin_lo;
    logic [31:0] tmin_hi;
    logic [63:0] tmax_lo;
    logic [31:0] tmax_hi;
    logic [47:0] nulls_seen;
    logic [47:0] value_count;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    function automatic logic [2:0] active_type();
        return (sh_type <= TY_F64) ? sh_type : TY_I64;
    endfunction

    function automatic logic is_fp_nan(input logic dbl, input logic [63:0] a);
        if (dbl) return (a[62:52] == 11'h7FF) && (a[51:0] != '0);
        return (a[30:23] == 8'hFF) && (a[22:0] != '0);
    endfunction

    // IEEE ordering: NaN is unordered and the two zeros compare equal.
    function automatic logic fp_less(input logic dbl, input logic [63:0] a, input logic [63:0] b);
        logic        sa;
        logic        sb;
        logic [62:0] ma;
        logic [62:0] mb;
        sa = dbl ? a[63] : a[31];
        sb = dbl ? b[63] : b[31];
        ma = dbl ? a[62:0] : {32'd0, a[30:0]};
        mb = dbl ? b[62:0] : {32'd0, b[30:0]};
        if (is_fp_nan(dbl, a) || is_fp_nan(dbl, b)) return 1'b0;
        if (ma == '0 && mb == '0) return 1'b0;
        if (sa != sb) return sa;
        if (sa) return ma > mb;
        return ma < mb;
    endfunction

    function automatic logic ordered_less(input logic [63:0] alo, input logic [31:0] ahi,
                                          input logic [63:0] blo, input logic [31:0] bhi);
        logic [31:0] flip32;
        logic [63:0] flip64;
        flip32 = sh_uns ? 32'd0 : 32'h8000_0000;
        flip64 = sh_uns ? 64'd0 : 64'h8000_0000_0000_0000;
        case (active_type())
            TY_BOOL: return alo[0] < blo[0];
            TY_I32:  return (alo[31:0] ^ flip32) < (blo[31:0] ^ flip32);
            TY_I96:  begin
                if ((ahi ^ flip32) != (bhi ^ flip32)) return (ahi ^ flip32) < (bhi ^ flip32);
                return alo < blo;
            end
            TY_F32:  return fp_less(1'b0, alo, blo);
            TY_F64:  return fp_less(1'b1, alo, blo);
            default: return (alo ^ flip64) < (blo ^ flip64);
        endcase
    endfunction

    task automatic load_batch_start();
        bmin_hi = '0;
        bmax_hi = '0;
        case (active_type())
            TY_BOOL: begin
                bmin_lo = 64'd1;
                bmax_lo = 64'd0;
            end
            TY_I32: begin
                bmin_lo = sh_uns ? 64'hFFFF_FFFF : 64'h7FFF_FFFF;
                bmax_lo = sh_uns ? 64'd0 : 64'h8000_0000;
            end
            TY_I96: begin
                bmin_lo = '1;
                bmin_hi = sh_uns ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
                bmax_lo = '0;
                bmax_hi = sh_uns ? 32'd0 : 32'h8000_0000;
            end
            TY_F32: begin
                bmin_lo = F32_MAX_BITS;
                bmax_lo = F32_LOW_BITS;
            end
            TY_F64: begin
                bmin_lo = F64_MAX_BITS;
                bmax_lo = F64_LOW_BITS;
            end
            default: begin
                bmin_lo = sh_uns ? '1 : 64'h7FFF_FFFF_FFFF_FFFF;
                bmax_lo = sh_uns ? 64'd0 : 64'h8000_0000_0000_0000;
            end
        endcase
    endtask

    task automatic clear_shadow();
        load_batch_start();
        batch_open  = 1'b0;
        have_totals = 1'b0;
        tmin_lo = '0;
        tmin_hi = '0;
        tmax_lo = '0;
        tmax_hi = '0;
        nulls_seen  = '0;
        value_count = '0;
    endtask

    task automatic merge_batch();
        logic [63:0] mn;
        logic [63:0] mx;
        logic        keep;
        mn = bmin_lo;
        mx = bmax_lo;
        keep = 1'b1;
        if (batch_open) begin
            if (active_type() == TY_F32) begin
                if (mn == F32_MAX_BITS && mx == F32_LOW_BITS) keep = 1'b0;
                if (mn == 64'd0) mn = F32_NEG_ZERO;
                if (mx == F32_NEG_ZERO) mx = 64'd0;
            end else if (active_type() == TY_F64) begin
                if (mn == F64_MAX_BITS && mx == F64_LOW_BITS) keep = 1'b0;
                if (mn == 64'd0) mn = F64_NEG_ZERO;
                if (mx == F64_NEG_ZERO) mx = 64'd0;
            end
            if (keep) begin
                if (!have_totals) begin
                    have_totals = 1'b1;
                    tmin_lo = mn;
                    tmin_hi = bmin_hi;
                    tmax_lo = mx;
                    tmax_hi = bmax_hi;
                end else begin
                    // On a tie the batch value replaces the stored one.
                    if (!ordered_less(tmin_lo, tmin_hi, mn, bmin_hi)) begin
                        tmin_lo = mn;
                        tmin_hi = bmin_hi;
                    end
                    if (!ordered_less(mx, bmax_hi, tmax_lo, tmax_hi)) begin
                        tmax_lo = mx;
                        tmax_hi = bmax_hi;
                    end
                end
            end
        end
        load_batch_start();
        batch_open = 1'b0;
    endtask

    task automatic predict_stats(input t_slot s);
        logic [63:0] vlo;
        logic [31:0] vhi;
        logic        nan;
        t_stats      r;
        if (s.cmd == CMD_CLEAR) begin
            clear_shadow();
        end else begin
            if (s.cmd == CMD_VALUE) begin
                vhi = '0;
                case (active_type())
                    TY_BOOL:        vlo = {63'd0, s.lo[0]};
                    TY_I32, TY_F32: vlo = {32'd0, s.lo[31:0]};
                    TY_I96: begin
                        vlo = s.lo;
                        vhi = s.hi;
                    end
                    default:        vlo = s.lo;
                endcase
                if (value_count != '1) value_count++;
                if (!batch_open) begin
                    load_batch_start();
                    batch_open = 1'b1;
                end
                nan = 1'b0;
                if (active_type() == TY_F32) nan = is_fp_nan(1'b0, vlo);
                if (active_type() == TY_F64) nan = is_fp_nan(1'b1, vlo);
                if (!nan) begin
                    if (!ordered_less(bmin_lo, bmin_hi, vlo, vhi)) begin
                        bmin_lo = vlo;
                        bmin_hi = vhi;
                    end
                    if (ordered_less(bmax_lo, bmax_hi, vlo, vhi)) begin
                        bmax_lo = vlo;
                        bmax_hi = vhi;
                    end
                end
            end else if (s.cmd == CMD_NULL) begin
                if (nulls_seen != '1) nulls_seen++;
            end
            if (s.last) merge_batch();
        end
        r.has    = have_totals;
        r.min_lo = tmin_lo;
        r.min_hi = tmin_hi;
        r.max_lo = tmax_lo;
        r.max_hi = tmax_hi;
        r.nulls  = nulls_seen;
        r.vals   = value_count;
        expected_stats.push_back(r);
    endtask

    // Predictor and checker, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_stats  w;
        t_slot   s;
        req_taken <= item.valid && item.ready;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
        if (i_rst_n) begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_VALUE_TYPE) sh_type = cfg.data;
                else if (cfg.index == REG_UNSIGNED_ORDER) sh_uns = cfg.data[0];
            end
            if (item.valid && item.ready) begin
                s.cmd  = item.cmd;
                s.lo   = item.value_low;
                s.hi   = item.value_high;
                s.last = item.last_in_batch;
                predict_stats(s);
            end
            if (stat.valid && stat.ready) begin
                if (expected_stats.size() == 0) begin
                    report("unexpected result", 64'd0, 64'd0);
                end else begin
                    w = expected_stats.pop_front();
                    if (stat.extremes_valid !== w.has)
                        report("extremes_valid", stat.extremes_valid, w.has);
                    if (stat.min_low !== w.min_lo) report("min_low", stat.min_low, w.min_lo);
                    if (stat.min_high !== w.min_hi) report("min_high", stat.min_high, w.min_hi);
                    if (stat.max_low !== w.max_lo) report("max_low", stat.max_low, w.max_lo);
                    if (stat.max_high !== w.max_hi) report("max_high", stat.max_high, w.max_hi);
                    if (stat.null_total !== w.nulls) report("null_total", stat.null_total, w.nulls);
                    if (stat.value_total !== w.vals) report("value_total", stat.value_total, w.vals);
                end
            end
        end
    end

    // Request driver: bursts of back-to-back requests separated by random gaps.
    always @(negedge i_clk) begin
        t_slot s;
        if (i_rst_n && !(item.valid && !req_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                item.valid <= 1'b0;
            end else if (pending_slots.size() > 0) begin
                s = pending_slots.pop_front();
                item.cmd           <= s.cmd;
                item.value_low     <= s.lo;
                item.value_high    <= s.hi;
                item.last_in_batch <= s.last;
                item.valid         <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                item.valid <= 1'b0;
            end
        end
    end

    // Result sink: ready follows one of three stall modes, each held for a while.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       stat.ready <= 1'b1;
            1:       stat.ready <= ($urandom_range(0, 3) != 0);
            default: stat.ready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    task automatic push_slot(input logic [1:0] cmd, input logic [63:0] lo,
                             input logic [31:0] hi, input logic last);
        t_slot s;
        s.cmd  = cmd;
        s.lo   = lo;
        s.hi   = hi;
        s.last = last;
        pending_slots.push_back(s);
    endtask

    task automatic wait_idle();
        while (pending_slots.size() > 0 || item.valid || expected_stats.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
        @(negedge i_clk);
        cfg.index = idx;
        cfg.data  = data;
        cfg.valid = 1'b1;
        do @(posedge i_clk); while (!cfg.ready);
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    function automatic logic [95:0] pick_value(input logic [2:0] ty);
        logic [63:0] lo;
        logic [31:0] hi;
        logic [31:0] w;
        lo = {$urandom, $urandom};
        hi = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4: lo[1:0] = 2'($urandom_range(0, 3));
            default: begin
                if (ty == TY_F32) begin
                    case ($urandom_range(0, 8))
                        0: w = 32'h0000_0000;
                        1: w = 32'h8000_0000;
                        2: w = 32'h7FC0_0000 | $urandom_range(0, 255);
                        3: w = 32'h7F80_0000;
                        4: w = 32'hFF80_0000;
                        5: w = F32_MAX_BITS[31:0];
                        6: w = F32_LOW_BITS[31:0];
                        7: w = $urandom_range(0, 3);
                        default: w = 32'hBF80_0000;
                    endcase
                    lo[31:0] = w;
                end else if (ty == TY_F64) begin
                    case ($urandom_range(0, 7))
                        0: lo = 64'd0;
                        1: lo = F64_NEG_ZERO;
                        2: lo = 64'h7FF8_0000_0000_0001;
                        3: lo = 64'h7FF0_0000_0000_0000;
                        4: lo = 64'hFFF0_0000_0000_0000;
                        5: lo = F64_MAX_BITS;
                        6: lo = F64_LOW_BITS;
                        default: lo = 64'h3FF0_0000_0000_0000;
                    endcase
                end else begin
                    case ($urandom_range(0, 5))
                        0: lo = '0;
                        1: lo = '1;
                        2: lo = 64'h8000_0000_8000_0000;
                        3: lo = 64'h7FFF_FFFF_7FFF_FFFF;
                        4: hi = 32'h8000_0000;
                        default: hi = 32'h7FFF_FFFF;
                    endcase
                end
            end
        endcase
        return {hi, lo};
    endfunction

    task automatic queue_batches(input logic [2:0] ty, input int count);
        int          n;
        int          len;
        int          r;
        logic [95:0] v;
        logic [1:0]  cmd;
        n = 0;
        while (n < count) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                v = pick_value(ty);
                if (r < 72) cmd = CMD_VALUE;
                else if (r < 92) cmd = CMD_NULL;
                else if (r < 96) cmd = CMD_SPARE;
                else if (r < 98) cmd = CMD_CLEAR;
                else cmd = CMD_VALUE;
                push_slot(cmd, v[63:0], v[95:64],
                          (k == len - 1) || ($urandom_range(0, 30) == 0));
                n++;
            end
        end
    endtask

    initial begin
        logic [2:0] ty;
        logic       uns;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        item.valid = 1'b0;
        item.cmd = CMD_VALUE;
        item.value_low = '0;
        item.value_high = '0;
        item.last_in_batch = 1'b0;
        stat.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_VALUE_TYPE;
        cfg.data = '0;
        error_count = 0;
        cycle_count = 0;
        req_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        stall_left = 0;
        sh_type = TY_I32;
        sh_uns = 1'b0;
        clear_shadow();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: signed int32 extremes, empty and unused-command batches, clear.
        push_slot(CMD_VALUE, 64'h7FFF_FFFF, '0, 1'b0);
        push_slot(CMD_VALUE, 64'h8000_0000, '0, 1'b1);
        push_slot(CMD_NULL, '0, '0, 1'b1);
        push_slot(CMD_SPARE, '1, '1, 1'b1);
        push_slot(CMD_VALUE, 64'hFFFF_FFFF_0000_0005, '1, 1'b1);
        push_slot(CMD_CLEAR, '0, '0, 1'b1);
        push_slot(CMD_VALUE, 64'h0000_0003, '0, 1'b1);
        wait_idle();
        // Float rules: NaN-only batch, zeros, infinities, a batch of defaults only.
        write_reg(REG_VALUE_TYPE, TY_F32);
        push_slot(CMD_VALUE, 64'h7FC0_0000, '0, 1'b1);
        push_slot(CMD_VALUE, 64'h0000_0000, '0, 1'b1);
        push_slot(CMD_VALUE, 64'h8000_0000, '0, 1'b1);
        push_slot(CMD_VALUE, F32_MAX_BITS, '0, 1'b0);
        push_slot(CMD_VALUE, F32_LOW_BITS, '0, 1'b1);
        push_slot(CMD_VALUE, 64'h7F80_0000, '0, 1'b0);
        push_slot(CMD_VALUE, 64'hFF80_0000, '0, 1'b1);
        wait_idle();
        // Unsigned int96 with extreme top words.
        write_reg(REG_VALUE_TYPE, TY_I96);
        write_reg(REG_UNSIGNED_ORDER, 3'd1);
        push_slot(CMD_CLEAR, '0, '0, 1'b0);
        push_slot(CMD_VALUE, '1, 32'hFFFF_FFFF, 1'b0);
        push_slot(CMD_VALUE, '0, 32'h0000_0000, 1'b1);
        push_slot(CMD_VALUE, '0, 32'h8000_0000, 1'b1);
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            ty = 3'($urandom_range(0, 5));
            uns = 1'($urandom_range(0, 1));
            if (p == 0) ty = TY_BOOL;
            if (p == 4) ty = TY_SPARE;
            if (p == 9) begin
                ty = TY_F64;
                uns = 1'b1;
            end
            write_reg(REG_VALUE_TYPE, ty);
            write_reg(REG_UNSIGNED_ORDER, {2'd0, uns});
            queue_batches((ty <= TY_F64) ? ty : TY_I64, 152);
            wait_idle();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
